[rtl/fpfa_pkg.sv]
// fpfa_pkg: shared types and constants for the fixed partition fit allocator
// no dependencies; imported by the allocator top level and its checker
package fpfa_pkg;

  localparam int NUM_PARTITIONS_DEF = 16;
  localparam int SIZE_WIDTH_DEF     = 16;

  // configuration register
  localparam int          CFG_W          = 5;
  localparam int          APB_ADDR_W     = 3;
  localparam logic [CFG_W-1:0] CFG_NUM_PART_RST = 5'd16;
  localparam logic        REG_NUM_PART   = 1'b0;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_WORST = 2'd1,
    POL_BEST  = 2'd2
  } policy_t;

  typedef enum logic [1:0] {
    ST_LOADED    = 2'd0,
    ST_ALLOCATED = 2'd1,
    ST_NOFIT     = 2'd2
  } status_t;

  typedef struct packed {
    logic        operation;
    logic [3:0]  partition_index;
    logic [15:0] partition_size;
    logic [15:0] request_size;
    logic [1:0]  fit_policy;
  } fpfa_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] chosen_index;
  } fpfa_out_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } fsm_t;

endpackage

[rtl/fixed_partition_fit_allocator.sv]
// fixed partition fit allocator: load requests and first/worst/best fit search
// one compare unit walks the partition table, one entry per cycle
// depends on fpfa_pkg
// a load request writes the table and registers its result, which then moves to the
// output register; an allocate request scans min(num_partitions, NUM_PARTITIONS)
// entries through the registered size memory read port, comparing each one entry behind
// the read; the next request can be taken as soon as the result reaches the output
// one request in flight at a time; a finished result may wait while the next is taken
// reset (rst_n, synchronous): clears table valid bits, taken flags, output and
// sets num_partitions to 16
module fixed_partition_fit_allocator
  import fpfa_pkg::*;
#(
  parameter int NUM_PARTITIONS = NUM_PARTITIONS_DEF,
  parameter int SIZE_WIDTH     = SIZE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fpfa_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fpfa_out_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int LIM_W = $clog2(NUM_PARTITIONS + 1);
  localparam int CNT_W = (LIM_W > CFG_W) ? LIM_W : CFG_W;

  fsm_t                  state_r, state_nxt;
  logic [CFG_W-1:0]      cfg_num_r;
  logic [NUM_PARTITIONS-1:0] loaded_r;
  logic [NUM_PARTITIONS-1:0] taken_r;
  logic [SIZE_WIDTH-1:0] mem [NUM_PARTITIONS];
  logic [SIZE_WIDTH-1:0] rd_data_r;
  logic                  rd_ld_r, rd_tk_r;
  logic                  pend_r, pend_nxt;
  logic [IDX_W-1:0]      pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SIZE_WIDTH-1:0] req_r, req_nxt;
  logic [1:0]            policy_r, policy_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      pick_r, pick_nxt;
  logic [SIZE_WIDTH-1:0] best_r, best_nxt;
  fpfa_out_t             res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  fpfa_out_t             out_data_r, out_data_nxt;

  logic                  accept;
  logic                  load_we;
  logic                  set_taken;
  logic                  rd_en;
  logic [IDX_W-1:0]      ld_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic [CNT_W-1:0]      limit_w;
  logic [SIZE_WIDTH-1:0] cur_size;
  logic                  eligible;
  logic                  better;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign ld_idx   = IDX_W'(in_data.partition_index);
  assign rd_idx   = cnt_r[IDX_W-1:0];
  assign limit_w  = (CNT_W'(cfg_num_r) > CNT_W'(NUM_PARTITIONS)) ?
                    CNT_W'(NUM_PARTITIONS) : CNT_W'(cfg_num_r);

  // entries never loaded read as size zero
  assign cur_size = rd_ld_r ? rd_data_r : '0;
  assign eligible = !rd_tk_r && (cur_size >= req_r);

  always_comb begin
    case (policy_r)
      POL_FIRST: better = !found_r;
      POL_WORST: better = (cur_size > best_r);
      POL_BEST:  better = !found_r || (cur_size < best_r);
      default:   better = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    policy_nxt    = policy_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    best_nxt      = best_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    load_we       = 1'b0;
    set_taken     = 1'b0;
    rd_en         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.operation == OP_LOAD) begin
            load_we   = (32'(in_data.partition_index) < NUM_PARTITIONS);
            res_nxt   = '{status: ST_LOADED, chosen_index: in_data.partition_index};
            state_nxt = S_DONE;
          end else if (in_data.fit_policy != POL_FIRST && in_data.fit_policy != POL_WORST &&
                       in_data.fit_policy != POL_BEST) begin
            res_nxt   = '{status: ST_NOFIT, chosen_index: 4'd0};
            state_nxt = S_DONE;
          end else begin
            cnt_nxt    = '0;
            found_nxt  = 1'b0;
            best_nxt   = '0;
            pick_nxt   = '0;
            req_nxt    = SIZE_WIDTH'(in_data.request_size);
            policy_nxt = in_data.fit_policy;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // read stage
        if (cnt_r < limit_w) begin
          rd_en        = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx;
          cnt_nxt      = cnt_r + 1'b1;
        end
        // compare stage, one entry behind the read
        if (pend_r && eligible && better) begin
          found_nxt = 1'b1;
          pick_nxt  = pend_idx_r;
          best_nxt  = cur_size;
        end
        if (!pend_r && cnt_r >= limit_w) begin
          set_taken = found_r;
          res_nxt   = found_r ? fpfa_out_t'{status: ST_ALLOCATED, chosen_index: 4'(pick_r)}
                              : fpfa_out_t'{status: ST_NOFIT, chosen_index: 4'd0};
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      loaded_r    <= '0;
      taken_r     <= '0;
      cfg_num_r   <= CFG_NUM_PART_RST;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_we) begin
        loaded_r[ld_idx] <= 1'b1;
        taken_r[ld_idx]  <= 1'b0;
      end
      if (set_taken) begin
        taken_r[pick_r] <= 1'b1;
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_NUM_PART) begin
        cfg_num_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    cnt_r      <= cnt_nxt;
    req_r      <= req_nxt;
    policy_r   <= policy_nxt;
    found_r    <= found_nxt;
    pick_r     <= pick_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // size table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[ld_idx] <= SIZE_WIDTH'(in_data.partition_size);
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
      rd_ld_r   <= loaded_r[rd_idx];
      rd_tk_r   <= taken_r[rd_idx];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_NUM_PART) ? 32'(cfg_num_r) : 32'd0;

endmodule

[rtl/fpfa_checker.sv]
// fpfa_checker: port-level assertions for the fixed partition fit allocator
// depends on fpfa_pkg; bound to fixed_partition_fit_allocator below
module fpfa_checker
  import fpfa_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input fpfa_out_t             out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no-fit always reports index zero
  a_nofit_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_NOFIT |-> out_data.chosen_index == 4'd0)
    else $error("no-fit result with non-zero index");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // synchronous reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (.*);

[sim/testbench.sv]
// testbench for the fixed partition fit allocator: directed and random requests,
// random idling on both channels, search count changed over the apb port
// depends on fpfa_pkg and the fixed_partition_fit_allocator rtl
`timescale 1ns / 1ps

module testbench;
  import fpfa_pkg::*;

  localparam int TABLE_DEPTH = NUM_PARTITIONS_DEF;
  localparam logic [APB_ADDR_W-1:0] NUM_PART_ADDR = APB_ADDR_W'(4 * int'(REG_NUM_PART));
  localparam int PHASE_REQUESTS = 200;
  localparam int DRAIN_CYCLES = 24;

  // expected results of the partition table, kept alongside the block
  class alloc_scoreboard;
    logic [15:0] part_size [TABLE_DEPTH];
    bit part_taken [TABLE_DEPTH];
    int unsigned search_count;
    fpfa_out_t expected_grants [$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        part_size[i] = '0;
        part_taken[i] = 1'b0;
      end
      search_count = int'(CFG_NUM_PART_RST);
      mismatches = 0;
    endfunction

    function void set_search_count(logic [CFG_W-1:0] count);
      search_count = (int'(count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    function fpfa_out_t predict_allocation(fpfa_in_t req);
      fpfa_out_t res;
      logic [15:0] best;
      bit found;
      int pick;
      int i;
      res.status = ST_NOFIT;
      res.chosen_index = '0;
      best = '0;
      found = 1'b0;
      pick = 0;
      if (req.operation == OP_LOAD) begin
        // a 4-bit index always lands inside the 16-entry table
        part_size[req.partition_index] = req.partition_size;
        part_taken[req.partition_index] = 1'b0;
        res.status = ST_LOADED;
        res.chosen_index = req.partition_index;
        return res;
      end
      for (i = 0; i < search_count; i++) begin
        if (part_taken[i] || part_size[i] < req.request_size) continue;
        case (req.fit_policy)
          POL_FIRST: begin
            if (!found) begin
              found = 1'b1;
              pick = i;
            end
          end
          POL_WORST: begin
            // strictly larger, so zero-size entries never win
            if (part_size[i] > best) begin
              best = part_size[i];
              pick = i;
              found = 1'b1;
            end
          end
          POL_BEST: begin
            if (!found || part_size[i] < best) begin
              best = part_size[i];
              pick = i;
              found = 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (found) begin
        part_taken[pick] = 1'b1;
        res.status = ST_ALLOCATED;
        res.chosen_index = 4'(pick);
      end
      return res;
    endfunction

    function void note_request(fpfa_in_t req);
      expected_grants.push_back(predict_allocation(req));
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(fpfa_out_t got);
      fpfa_out_t want;
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("result status %0d index %0d with nothing outstanding",
                                  got.status, got.chosen_index));
        return;
      end
      want = expected_grants.pop_front();
      if (got.status !== want.status || got.chosen_index !== want.chosen_index)
        report_mismatch($sformatf("got status %0d index %0d, expected status %0d index %0d",
                                  got.status, got.chosen_index,
                                  want.status, want.chosen_index));
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fpfa_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fpfa_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  alloc_scoreboard sb = new();
  bit no_idle = 1'b0;
  int stall_left = 0;

  fixed_partition_fit_allocator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sampled before the edge's own updates land, so no race with the block
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(input fpfa_in_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic load_partition(input int idx, input logic [15:0] size);
    fpfa_in_t req;
    req.operation = OP_LOAD;
    req.partition_index = 4'(idx);
    req.partition_size = size;
    req.request_size = 16'($urandom);
    req.fit_policy = 2'($urandom);
    send_request(req);
  endtask

  task automatic allocate(input logic [1:0] policy, input logic [15:0] size);
    fpfa_in_t req;
    req.operation = OP_ALLOC;
    req.partition_index = 4'($urandom);
    req.partition_size = 16'($urandom);
    req.request_size = size;
    req.fit_policy = policy;
    send_request(req);
  endtask

  // write the search count, then read it back; only while the block is idle
  task automatic set_search_count(input logic [CFG_W-1:0] count);
    in_valid <= 1'b0;
    // let the last accepted request reach the scoreboard first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= NUM_PART_ADDR;
    pwdata <= 32'(count);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_search_count(count);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(count))
      sb.report_mismatch($sformatf("search count read back %0h, written %0h", prdata, count));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_request();
    fpfa_in_t req;
    int roll;
    req.operation = ($urandom_range(0, 99) < 45) ? OP_LOAD : OP_ALLOC;
    req.partition_index = 4'($urandom);
    req.partition_size = 16'($urandom);
    req.request_size = 16'($urandom);
    roll = $urandom_range(0, 99);
    if (req.operation == OP_LOAD) begin
      if (roll < 25) req.partition_size = 16'($urandom_range(0, 31));
      else if (roll < 35) req.partition_size = '0;
      else if (roll < 45) req.partition_size = 16'hffff;
    end else begin
      // aim many requests at a size already in the table
      if (roll < 30) req.request_size = sb.part_size[$urandom_range(0, TABLE_DEPTH - 1)];
      else if (roll < 50) req.request_size = 16'($urandom_range(0, 31));
      else if (roll < 60) req.request_size = '0;
      else if (roll < 65) req.request_size = 16'hffff;
    end
    roll = $urandom_range(0, 99);
    if (roll < 31) req.fit_policy = POL_FIRST;
    else if (roll < 62) req.fit_policy = POL_WORST;
    else if (roll < 94) req.fit_policy = POL_BEST;
    else req.fit_policy = 2'd3;
    send_request(req);
  endtask

  initial begin
    logic [CFG_W-1:0] counts [8];
    counts = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd9,
               CFG_W'($urandom_range(1, 16)), CFG_W'($urandom)};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: zero-size entries for first and best fit, never for worst fit
    allocate(POL_FIRST, 16'd0);
    allocate(POL_WORST, 16'd0);
    allocate(POL_BEST, 16'd0);
    load_partition(15, 16'hffff);
    load_partition(0, 16'd0);
    load_partition(3, 16'd100);
    load_partition(5, 16'd100);
    load_partition(7, 16'd50);
    allocate(POL_BEST, 16'd60);
    allocate(POL_WORST, 16'd1);
    allocate(POL_WORST, 16'd1);
    allocate(POL_FIRST, 16'hffff);
    // reload of a taken partition frees it
    load_partition(15, 16'hffff);
    allocate(POL_FIRST, 16'hffff);
    allocate(2'd3, 16'd0);
    allocate(POL_WORST, 16'd0);
    load_partition(8, 16'haaaa);
    load_partition(9, 16'h5555);
    allocate(POL_BEST, 16'h5000);
    allocate(POL_FIRST, 16'd0);
    allocate(POL_BEST, 16'hffff);
    allocate(POL_WORST, 16'hffff);

    foreach (counts[p]) begin
      set_search_count(counts[p]);
      no_idle = (p == 1);
      repeat (PHASE_REQUESTS) random_request();
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[fixed_partition_fit_allocator.f]
rtl/fpfa_pkg.sv
rtl/fixed_partition_fit_allocator.sv
rtl/fpfa_checker.sv
sim/testbench.sv
